FILE: hw/rtl/per_id_latency_stats_table_unit_assert.svh
// Assertion macros for the per-id latency statistics table.
// Included by RTL files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef PER_ID_LATENCY_STATS_TABLE_UNIT_ASSERT_SVH
`define PER_ID_LATENCY_STATS_TABLE_UNIT_ASSERT_SVH

// checked only out of reset
`define PLST_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("plst assertion failed");

// checked at every edge, reset included
`define PLST_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("plst assertion failed");

`endif

FILE: hw/rtl/plst_pkg.sv
// Package for the per-id latency statistics table: word types, codes, constants.
// No dependencies.
`default_nettype none

package plst_pkg;

    localparam int NUM_ENTRIES_DEF = 16;

    localparam logic [1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [1:0] MODE_DEPART  = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic [4:0] ENTRIES_IN_USE_RST = 5'd16;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  entry_id;
        logic [31:0] latency;
    } t_in_word;

    typedef struct packed {
        logic        id_error;
        logic [31:0] arrival_count;
        logic [31:0] departure_count;
        logic [31:0] min_latency;
        logic [31:0] max_latency;
        logic [47:0] total_latency;
    } t_out_word;

    typedef struct packed {
        logic [31:0] arrivals;
        logic [31:0] departures;
        logic [31:0] min_lat;
        logic [31:0] max_lat;
        logic [47:0] total;
    } t_stats;

    localparam t_stats STATS_RST = '{
        arrivals:   32'd0,
        departures: 32'd0,
        min_lat:    32'hFFFF_FFFF,
        max_lat:    32'd0,
        total:      48'd0
    };

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/per_id_latency_stats_table_unit.sv
// An accepted input word is held in r_s1 while its entry is read; its result word is then registered in r_out.
// Throughput: one word per cycle while neither o_stall nor i_stall holds the flow; the registered
// memory read and the write-back of the previous word meet through a bypass register.
// Reset: synchronous, active low; afterwards the table is swept entry by entry to its
// reset values, with o_stall high throughout.
// Top level of the per-id latency statistics table; uses plst_pkg, plst_cfg, plst_mem.
`default_nettype none

module per_id_latency_stats_table_unit #(
    parameter int NUM_ENTRIES = plst_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire plst_pkg::t_in_word i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output plst_pkg::t_out_word o_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import plst_pkg::*;

    `include "per_id_latency_stats_table_unit_assert.svh"

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_idx, n_clr_idx;
    logic            clr_wr;

    logic [4:0]      entries_in_use;

    logic            in_accept;
    logic            r_s1_valid;
    t_in_word        r_s1;
    logic            s1_advance;
    logic            r_byp;
    t_stats          r_byp_data;

    t_stats          rd_data, cur, upd;
    logic            id_err;
    logic            upd_wr;
    logic [48:0]     sum;
    t_out_word       result;

    logic            r_out_valid;
    t_out_word       r_out;

    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    t_stats          mem_wr_data;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   s1_addr;

    plst_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_entries_in_use (entries_in_use)
    );

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        clr_wr    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clr_wr    = 1'b1;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(NUM_ENTRIES - 1)) begin
                    n_state   = ST_RUN;
                    n_clr_idx = '0;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign s1_advance = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = (r_state != ST_RUN) || (r_s1_valid && !s1_advance);
    assign in_accept  = i_valid && !o_stall;
    assign rd_addr    = AW'(i_data.entry_id);
    assign s1_addr    = AW'(r_s1.entry_id);

    // read-modify-write of the addressed entry
    assign cur = r_byp ? r_byp_data : rd_data;

    always_comb begin
        id_err = !(({1'b0, r_s1.entry_id} < entries_in_use)
                   && (32'(r_s1.entry_id) < NUM_ENTRIES));
        upd = cur;
        sum = {1'b0, cur.total} + 49'(r_s1.latency);
        case (r_s1.mode)
            MODE_ARRIVAL: begin
                if (cur.arrivals != '1) begin
                    upd.arrivals = cur.arrivals + 32'd1;
                end
            end
            MODE_DEPART: begin
                if (cur.departures != '1) begin
                    upd.departures = cur.departures + 32'd1;
                end
                upd.total = sum[48] ? '1 : sum[47:0];
                if (r_s1.latency > cur.max_lat) begin
                    upd.max_lat = r_s1.latency;
                end
                if (r_s1.latency < cur.min_lat) begin
                    upd.min_lat = r_s1.latency;
                end
            end
            MODE_READ: begin
                upd = cur;
            end
            default: begin
                upd = cur;
            end
        endcase
        if (id_err) begin
            result = '0;
            result.id_error = 1'b1;
        end else begin
            result.id_error        = 1'b0;
            result.arrival_count   = upd.arrivals;
            result.departure_count = upd.departures;
            result.min_latency     = upd.min_lat;
            result.max_latency     = upd.max_lat;
            result.total_latency   = upd.total;
        end
    end

    assign upd_wr      = s1_advance && !id_err;
    assign mem_wr_en   = clr_wr || upd_wr;
    assign mem_wr_addr = clr_wr ? r_clr_idx : s1_addr;
    assign mem_wr_data = clr_wr ? STATS_RST : upd;

    plst_mem #(
        .DEPTH (NUM_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
            r_byp      <= upd_wr && (s1_addr == rd_addr);
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1       <= i_data;
            r_byp_data <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `PLST_ASSERT(a_no_accept_in_clear, (r_state == ST_CLEAR) |-> !in_accept)
    `PLST_ASSERT(a_one_writer, !(clr_wr && upd_wr))
    `PLST_ASSERT(a_byp_needs_item, r_byp |-> r_s1_valid)
    `PLST_ASSERT(a_min_le_max,
        (o_valid && !o_data.id_error && (o_data.departure_count != 32'd0))
        |-> (o_data.min_latency <= o_data.max_latency))
    `PLST_ASSERT_ALWAYS(a_rst_clears_pipe, !i_rst_n |=> (!r_s1_valid && !r_out_valid))

endmodule

`default_nettype wire

FILE: hw/rtl/plst_cfg.sv
// APB-style register port holding entries_in_use.
// Depends on plst_pkg.
`default_nettype none

module plst_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [4:0]       o_entries_in_use
);
    import plst_pkg::*;

    logic [4:0] r_entries;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ENTRIES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_IN_USE_RST;
        end else if (wr_hit) begin
            r_entries <= pwdata[4:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_ENTRIES_IN_USE) begin
            prdata = {27'd0, r_entries};
        end
    end

    assign o_entries_in_use = r_entries;

endmodule

`default_nettype wire

FILE: hw/rtl/plst_mem.sv
// Statistics memory: one write port, one read port with registered read data.
// Depends on plst_pkg.
`default_nettype none

module plst_mem #(
    parameter int DEPTH = plst_pkg::NUM_ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output plst_pkg::t_stats      o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire plst_pkg::t_stats i_wr_data
);
    import plst_pkg::*;

    t_stats mem [DEPTH];
    t_stats r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
